// ----- design/focl_pkg.sv -----
// Shared types, constants and saturation helpers for the FOC current loop.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package focl_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int DUTY_WIDTH = 13;
   localparam int LIMIT_WIDTH = 15;
   localparam int GAIN_WIDTH = 16;

   localparam int INV_SQRT3_Q16 = 37837;
   localparam int HALF_SQRT3_Q16 = 56756;
   localparam int DUTY_MID = 2048;
   localparam int DUTY_MAX = 4096;

   typedef enum logic [3:0] {
      CSR_D_PROP_GAIN    = 4'd0,
      CSR_D_INT_GAIN     = 4'd1,
      CSR_Q_PROP_GAIN    = 4'd2,
      CSR_Q_INT_GAIN     = 4'd3,
      CSR_VOLTAGE_LIMIT  = 4'd4,
      CSR_BUS_VOLTAGE    = 4'd5,
      CSR_COMP_AMPLITUDE = 4'd6,
      CSR_COMP_THRESHOLD = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] phase_a_current;
      logic signed [DATA_WIDTH-1:0] phase_b_current;
      logic signed [DATA_WIDTH-1:0] angle_sine;
      logic signed [DATA_WIDTH-1:0] angle_cosine;
      logic signed [DATA_WIDTH-1:0] d_current_target;
      logic signed [DATA_WIDTH-1:0] q_current_target;
   } req_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0]        duty_a;
      logic [DUTY_WIDTH-1:0]        duty_b;
      logic [DUTY_WIDTH-1:0]        duty_c;
      logic signed [DATA_WIDTH-1:0] d_current;
      logic signed [DATA_WIDTH-1:0] q_current;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  d_prop_gain;
      logic [GAIN_WIDTH-1:0]  d_int_gain;
      logic [GAIN_WIDTH-1:0]  q_prop_gain;
      logic [GAIN_WIDTH-1:0]  q_int_gain;
      logic [LIMIT_WIDTH-1:0] voltage_limit;
      logic [LIMIT_WIDTH-1:0] bus_voltage;
      logic [LIMIT_WIDTH-1:0] comp_amplitude;
      logic [LIMIT_WIDTH-1:0] comp_threshold;
   } cfg_type;

   // Saturate a wide signed value to the data width.
   function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [39:0] x);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'((2 ** (DATA_WIDTH - 1)) - 1);
      lo = -hi - 40'sd1;
      if (x > hi) begin
         return hi[DATA_WIDTH-1:0];
      end else if (x < lo) begin
         return lo[DATA_WIDTH-1:0];
      end
      return x[DATA_WIDTH-1:0];
   endfunction

   // Clamp to the symmetric voltage limit.
   function automatic logic signed [DATA_WIDTH-1:0] clamp_lim(input logic signed [24:0] x,
                                                              input logic [LIMIT_WIDTH-1:0] lim);
      logic signed [24:0] pos;
      logic signed [24:0] neg;
      pos = 25'($signed({1'b0, lim}));
      neg = -pos;
      if (x > pos) begin
         return pos[DATA_WIDTH-1:0];
      end else if (x < neg) begin
         return neg[DATA_WIDTH-1:0];
      end
      return x[DATA_WIDTH-1:0];
   endfunction

endpackage

// ----- design/focl_front.sv -----
// Request front end: a two-entry queue that takes samples from the input
// channel and holds them until the back end is free. Uses focl_pkg.
`timescale 1ns / 1ps

module focl_front
   import focl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type in_data,
   output logic    deq_valid,
   input  logic    deq_pop,
   output req_type deq_data
);

   req_type    data_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign deq_valid = (count_ff != 2'd0);
   assign deq_data  = data_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = deq_pop && deq_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

   // The pointers and the fill count must agree.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("focl_front: pointers disagree with fill count");

endmodule

// ----- design/focl_div.sv -----
// Iterative divider rounding to nearest, ties away from zero: one quotient
// bit per cycle. Uses focl_pkg for widths.
`timescale 1ns / 1ps

module focl_div
   import focl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [31:0]     num,
   input  logic [LIMIT_WIDTH-1:0] den,
   output logic                   done,
   output logic signed [32:0]     quot
);

   logic [31:0]            mag_ff;
   logic [LIMIT_WIDTH:0]   rem_ff;
   logic [31:0]            quo_ff;
   logic [LIMIT_WIDTH-1:0] den_ff;
   logic                   neg_ff;
   logic [4:0]             count_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [31:0]            abs_num;
   logic [LIMIT_WIDTH:0]   rem_sh;
   logic                   fits;

   assign abs_num = num[31] ? 32'(-num) : 32'(num);
   assign rem_sh  = {rem_ff[LIMIT_WIDTH-1:0], mag_ff[31]};
   assign fits    = (rem_sh >= {1'b0, den_ff});
   assign done    = done_ff;
   assign quot    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // Adding half the divisor to the magnitude gives round to nearest.
            mag_ff   <= abs_num + 32'(den >> 1);
            den_ff   <= den;
            neg_ff   <= num[31];
            rem_ff   <= '0;
            quo_ff   <= '0;
            count_ff <= 5'd0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_ff   <= {quo_ff[30:0], fits};
            mag_ff   <= {mag_ff[30:0], 1'b0};
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("focl_div: started while busy");

endmodule

// ----- design/focl_back.sv -----
// Back end of the current loop: a step sequencer around one shared 18x18
// multiplier and the iterative divider. Holds the PI integrators.
// Uses focl_pkg and focl_div.
`timescale 1ns / 1ps

module focl_back
   import focl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    deq_valid,
   output logic    deq_pop,
   input  req_type deq_data,
   output logic    out_push,
   input  logic    out_free,
   output rsp_type out_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_USE, ST_DIV, ST_DUTY, ST_OUT
   } state_type;

   localparam logic [4:0] STEP_BETA  = 5'd0;
   localparam logic [4:0] STEP_D_AC  = 5'd1;
   localparam logic [4:0] STEP_D_BS  = 5'd2;
   localparam logic [4:0] STEP_Q_AS  = 5'd3;
   localparam logic [4:0] STEP_Q_BC  = 5'd4;
   localparam logic [4:0] STEP_D_INT = 5'd5;
   localparam logic [4:0] STEP_D_OUT = 5'd6;
   localparam logic [4:0] STEP_Q_INT = 5'd7;
   localparam logic [4:0] STEP_Q_OUT = 5'd8;
   localparam logic [4:0] STEP_VA_DC = 5'd9;
   localparam logic [4:0] STEP_VA_QS = 5'd10;
   localparam logic [4:0] STEP_VB_DS = 5'd11;
   localparam logic [4:0] STEP_VB_QC = 5'd12;
   localparam logic [4:0] STEP_V_PH  = 5'd13;
   localparam logic [4:0] STEP_RA_DC = 5'd14;
   localparam logic [4:0] STEP_RA_QS = 5'd15;
   localparam logic [4:0] STEP_RB_DS = 5'd16;
   localparam logic [4:0] STEP_RB_QC = 5'd17;
   localparam logic [4:0] STEP_R_PH  = 5'd18;
   localparam logic [4:0] STEP_COMP  = 5'd19;
   localparam logic [4:0] STEP_DUTY  = 5'd20;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   state_type         state_ff;
   logic [4:0]        pc_ff;
   logic [1:0]        ph_ff;
   req_type           item_ff;
   logic signed [35:0] prod_ff;
   logic signed [35:0] acc_ff;
   data_type          be_ff, id_ff, iq_ff;
   data_type          integ_d_ff, integ_q_ff, vd_ff, vq_ff;
   data_type          ual_ff, ube_ff, ral_ff, rbe_ff;
   data_type          v_ff [3];
   data_type          ref_ff [3];
   logic [DUTY_WIDTH-1:0] duty_ff [3];
   logic              div_start_ff;
   logic signed [31:0] div_num_ff;
   logic [LIMIT_WIDTH-1:0] div_den_ff;

   logic              div_done;
   logic signed [32:0] div_quot;
   logic signed [17:0] mul_a, mul_b;
   logic signed [16:0] err_d, err_q;
   logic signed [36:0] sum_acc;
   data_type          shr14;
   data_type          beta_val;
   logic signed [36:0] clarke_base;
   data_type          ph1_val, ph2_val;
   logic signed [24:0] pi_p;
   data_type          pi_integ;
   data_type          pi_res;
   data_type          cur_ref, cur_v, vmax, vmin;
   logic signed [16:0] thr_s;
   logic              ref_hi, ref_lo;
   data_type          amp_s;
   data_type          v_direct;
   data_type          v_divided;
   logic signed [17:0] duty_diff;
   logic signed [33:0] duty_sum;
   logic [DUTY_WIDTH-1:0] duty_val;

   focl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign err_d = 17'(item_ff.d_current_target) - 17'(id_ff);
   assign err_q = 17'(item_ff.q_current_target) - 17'(iq_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (pc_ff)
         STEP_BETA: begin
            mul_a = 18'(item_ff.phase_a_current) + (18'(item_ff.phase_b_current) <<< 1);
            mul_b = 18'(INV_SQRT3_Q16);
         end
         STEP_D_AC: begin
            mul_a = 18'(item_ff.phase_a_current);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_D_BS: begin
            mul_a = 18'(be_ff);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_Q_AS: begin
            mul_a = -18'(item_ff.phase_a_current);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_Q_BC: begin
            mul_a = 18'(be_ff);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_D_INT: begin
            mul_a = 18'(err_d);
            mul_b = $signed({2'b00, cfg.d_int_gain});
         end
         STEP_D_OUT: begin
            mul_a = 18'(err_d);
            mul_b = $signed({2'b00, cfg.d_prop_gain});
         end
         STEP_Q_INT: begin
            mul_a = 18'(err_q);
            mul_b = $signed({2'b00, cfg.q_int_gain});
         end
         STEP_Q_OUT: begin
            mul_a = 18'(err_q);
            mul_b = $signed({2'b00, cfg.q_prop_gain});
         end
         STEP_VA_DC: begin
            mul_a = 18'(vd_ff);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_VA_QS: begin
            mul_a = -18'(vq_ff);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_VB_DS: begin
            mul_a = 18'(vd_ff);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_VB_QC: begin
            mul_a = 18'(vq_ff);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_V_PH: begin
            mul_a = 18'(ube_ff);
            mul_b = 18'(HALF_SQRT3_Q16);
         end
         STEP_RA_DC: begin
            mul_a = 18'(item_ff.d_current_target);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_RA_QS: begin
            mul_a = -18'(item_ff.q_current_target);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_RB_DS: begin
            mul_a = 18'(item_ff.d_current_target);
            mul_b = 18'(item_ff.angle_sine);
         end
         STEP_RB_QC: begin
            mul_a = 18'(item_ff.q_current_target);
            mul_b = 18'(item_ff.angle_cosine);
         end
         STEP_R_PH: begin
            mul_a = 18'(rbe_ff);
            mul_b = 18'(HALF_SQRT3_Q16);
         end
         STEP_COMP: begin
            mul_a = 18'(ref_ff[ph_ff]);
            mul_b = $signed({3'b000, cfg.comp_amplitude});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Results of the step whose product sits in prod_ff. Every product shift
   // rounds to nearest with ties toward plus infinity.
   always_comb begin
      sum_acc     = 37'(acc_ff) + 37'(prod_ff);
      shr14       = sat_data(40'((sum_acc + 37'sd8192) >>> 14));
      beta_val    = sat_data(40'((prod_ff + 36'sd32768) >>> 16));
      clarke_base = -(37'((pc_ff == STEP_V_PH) ? ual_ff : ral_ff) <<< 15);
      ph1_val     = sat_data(40'((clarke_base + 37'(prod_ff) + 37'sd32768) >>> 16));
      ph2_val     = sat_data(40'((clarke_base - 37'(prod_ff) + 37'sd32768) >>> 16));
      pi_p        = 25'((prod_ff + 36'sd2048) >>> 12);
      pi_integ    = (pc_ff == STEP_D_INT || pc_ff == STEP_D_OUT) ? integ_d_ff : integ_q_ff;
      pi_res      = clamp_lim(pi_p + 25'(pi_integ), cfg.voltage_limit);

      cur_ref = ref_ff[ph_ff];
      cur_v   = v_ff[ph_ff];
      thr_s   = $signed({2'b00, cfg.comp_threshold});
      ref_hi  = 17'(cur_ref) > thr_s;
      ref_lo  = 17'(cur_ref) < -thr_s;
      amp_s   = $signed({1'b0, cfg.comp_amplitude});
      if (ref_hi) begin
         v_direct = sat_data(40'(cur_v) + 40'(amp_s));
      end else if (ref_lo) begin
         v_direct = sat_data(40'(cur_v) - 40'(amp_s));
      end else begin
         v_direct = cur_v;
      end
      v_divided = sat_data(40'(cur_v) + 40'(div_quot));

      vmax = v_ff[0];
      vmin = v_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (v_ff[k] > vmax) begin
            vmax = v_ff[k];
         end
         if (v_ff[k] < vmin) begin
            vmin = v_ff[k];
         end
      end
      duty_diff = (18'(cur_v) <<< 1) - 18'(vmax) - 18'(vmin);
      duty_sum  = 34'(div_quot) + 34'(DUTY_MID);
      if (duty_sum < 34'sd0) begin
         duty_val = '0;
      end else if (duty_sum > 34'(DUTY_MAX)) begin
         duty_val = DUTY_WIDTH'(DUTY_MAX);
      end else begin
         duty_val = duty_sum[DUTY_WIDTH-1:0];
      end
   end

   assign deq_pop  = (state_ff == ST_IDLE) && deq_valid;
   assign out_push = (state_ff == ST_OUT) && out_free;

   always_comb begin
      out_data.duty_a    = duty_ff[0];
      out_data.duty_b    = duty_ff[1];
      out_data.duty_c    = duty_ff[2];
      out_data.d_current = id_ff;
      out_data.q_current = iq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= STEP_BETA;
         ph_ff        <= 2'd0;
         integ_d_ff   <= '0;
         integ_q_ff   <= '0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (deq_valid) begin
                  item_ff  <= deq_data;
                  pc_ff    <= STEP_BETA;
                  ph_ff    <= 2'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_USE;
            end
            ST_USE: begin
               pc_ff    <= pc_ff + 5'd1;
               state_ff <= ST_MUL;
               unique case (pc_ff)
                  STEP_BETA:  be_ff <= beta_val;
                  STEP_D_AC, STEP_Q_AS, STEP_VA_DC, STEP_VB_DS, STEP_RA_DC, STEP_RB_DS:
                     acc_ff <= prod_ff;
                  STEP_D_BS:  id_ff <= shr14;
                  STEP_Q_BC:  iq_ff <= shr14;
                  STEP_D_INT: integ_d_ff <= pi_res;
                  STEP_D_OUT: vd_ff <= pi_res;
                  STEP_Q_INT: integ_q_ff <= pi_res;
                  STEP_Q_OUT: vq_ff <= pi_res;
                  STEP_VA_QS: ual_ff <= shr14;
                  STEP_VB_QC: ube_ff <= shr14;
                  STEP_V_PH: begin
                     v_ff[0] <= ual_ff;
                     v_ff[1] <= ph1_val;
                     v_ff[2] <= ph2_val;
                  end
                  STEP_RA_QS: ral_ff <= shr14;
                  STEP_RB_QC: rbe_ff <= shr14;
                  STEP_R_PH: begin
                     ref_ff[0] <= ral_ff;
                     ref_ff[1] <= ph1_val;
                     ref_ff[2] <= ph2_val;
                     ph_ff     <= 2'd0;
                  end
                  STEP_COMP: begin
                     // Inside the band the compensation is linear and needs a divide;
                     // a zero threshold leaves only a zero current there.
                     if (!ref_hi && !ref_lo && cfg.comp_threshold != '0) begin
                        div_num_ff   <= 32'(prod_ff);
                        div_den_ff   <= cfg.comp_threshold;
                        div_start_ff <= 1'b1;
                        pc_ff        <= pc_ff;
                        state_ff     <= ST_DIV;
                     end else begin
                        v_ff[ph_ff] <= v_direct;
                        if (ph_ff == 2'd2) begin
                           ph_ff    <= 2'd0;
                           state_ff <= ST_DUTY;
                        end else begin
                           ph_ff <= ph_ff + 2'd1;
                           pc_ff <= pc_ff;
                        end
                     end
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_DUTY: begin
               if (cfg.bus_voltage == '0) begin
                  duty_ff[ph_ff] <= DUTY_WIDTH'(DUTY_MID);
                  if (ph_ff == 2'd2) begin
                     state_ff <= ST_OUT;
                  end else begin
                     ph_ff <= ph_ff + 2'd1;
                  end
               end else begin
                  div_num_ff   <= 32'(duty_diff) <<< 11;
                  div_den_ff   <= cfg.bus_voltage;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (pc_ff == STEP_COMP) begin
                     v_ff[ph_ff] <= v_divided;
                     if (ph_ff == 2'd2) begin
                        ph_ff    <= 2'd0;
                        pc_ff    <= STEP_DUTY;
                        state_ff <= ST_DUTY;
                     end else begin
                        ph_ff    <= ph_ff + 2'd1;
                        state_ff <= ST_MUL;
                     end
                  end else begin
                     duty_ff[ph_ff] <= duty_val;
                     if (ph_ff == 2'd2) begin
                        state_ff <= ST_OUT;
                     end else begin
                        ph_ff    <= ph_ff + 2'd1;
                        state_ff <= ST_DUTY;
                     end
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) div_done |-> (state_ff == ST_DIV))
      else $error("focl_back: divider finished outside a divide step");

endmodule

// ----- design/foc_current_loop_unit.sv -----
// Top level of the FOC current loop: configuration registers, request queue,
// sequenced back end and the result register. Uses focl_pkg, focl_front, focl_back.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on req_push/req_full; one request is one PWM-period sample
//   (phase currents, angle sine/cosine, d/q current targets). A two-entry queue
//   takes requests while the back end is busy.
//   Results leave on rsp_empty/rsp_pop: three duties and the measured d/q
//   currents, exactly one result per request, in request order.
//   Steps: the request is taken into the back end, then 19 multiplier steps,
//   three compensation steps, each with a divide when it needs one, three
//   duty divides (none when the bus voltage is zero) and the result register.
//   The shared divider does the divides. The back end takes the next request
//   only once the result of the last one has passed to the result register.
//   The configuration port (csr_write/csr_index/csr_data) writes one register
//   per cycle and must be used only while the block holds no request.
//   Reset loads the default gains and limits and clears both integrators,
//   the queue and the result register.
//   When the receiver does not pop, the finished result waits in the result
//   register; the back end holds its next result, and the queue fills up
//   until req_full rises.

module foc_current_loop_unit
   import focl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_payload,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_payload,
   input  logic        csr_write,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    deq_valid;
   logic    deq_pop;
   req_type deq_data;
   logic    out_push;
   logic    out_free;
   rsp_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.d_prop_gain    <= 16'd6144;
         cfg_ff.d_int_gain     <= 16'd205;
         cfg_ff.q_prop_gain    <= 16'd6144;
         cfg_ff.q_int_gain     <= 16'd205;
         cfg_ff.voltage_limit  <= 15'd2048;
         cfg_ff.bus_voltage    <= 15'd24576;
         cfg_ff.comp_amplitude <= 15'd0;
         cfg_ff.comp_threshold <= 15'd102;
      end else if (csr_write) begin
         case (csr_index)
            CSR_D_PROP_GAIN:    cfg_ff.d_prop_gain    <= csr_data;
            CSR_D_INT_GAIN:     cfg_ff.d_int_gain     <= csr_data;
            CSR_Q_PROP_GAIN:    cfg_ff.q_prop_gain    <= csr_data;
            CSR_Q_INT_GAIN:     cfg_ff.q_int_gain     <= csr_data;
            CSR_VOLTAGE_LIMIT:  cfg_ff.voltage_limit  <= csr_data[LIMIT_WIDTH-1:0];
            CSR_BUS_VOLTAGE:    cfg_ff.bus_voltage    <= csr_data[LIMIT_WIDTH-1:0];
            CSR_COMP_AMPLITUDE: cfg_ff.comp_amplitude <= csr_data[LIMIT_WIDTH-1:0];
            CSR_COMP_THRESHOLD: cfg_ff.comp_threshold <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   focl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .in_data   (req_payload),
      .deq_valid (deq_valid),
      .deq_pop   (deq_pop),
      .deq_data  (deq_data)
   );

   focl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .deq_valid (deq_valid),
      .deq_pop   (deq_pop),
      .deq_data  (deq_data),
      .out_push  (out_push),
      .out_free  (out_free),
      .out_data  (out_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_pop;
   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         rsp_ff <= out_data;
      end
   end

   // A waiting result is never overwritten before it is popped.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pop) |=> $stable(rsp_ff))
      else $error("foc_current_loop_unit: waiting result overwritten");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for foc_current_loop_unit: fixed-point current loop predictor,
// directed and random samples under several flow-control patterns. Depends on focl_pkg.
`timescale 1ns / 1ps

module tb_top;
   import focl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_payload = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   foc_current_loop_unit i_dut (.*);

   always #4 clock = ~clock;

   // Predictor state and register copies.
   longint d_kp, d_ki, q_kp, q_ki, v_lim, bus_v, c_amp, c_thr;
   longint d_integ, q_integ;
   rsp_type expected_duties[$];
   int mismatches = 0;
   int results_seen = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   function automatic longint sat16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function automatic longint clampv(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // Round to nearest, ties toward +infinity.
   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Round to nearest, ties away from zero.
   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint run_pi(inout longint integ, input longint err,
                                     input longint kp, input longint ki);
      integ = clampv(integ + round_shift(ki * err, 12), -v_lim, v_lim);
      return clampv(round_shift(kp * err, 12) + integ, -v_lim, v_lim);
   endfunction

   function automatic void rotate_to_phases(input longint d, input longint q,
                                            input longint s, input longint c,
                                            output longint ph[3]);
      longint al, be;
      al = sat16(round_shift(d * c - q * s, 14));
      be = sat16(round_shift(d * s + q * c, 14));
      ph[0] = al;
      ph[1] = sat16(round_shift(-al * 32768 + be * HALF_SQRT3_Q16, 16));
      ph[2] = sat16(round_shift(-al * 32768 - be * HALF_SQRT3_Q16, 16));
   endfunction

   function automatic longint deadtime_comp(longint i);
      if (i > c_thr) return c_amp;
      if (i < -c_thr) return -c_amp;
      if (c_thr == 0) return 0;
      return round_div(c_amp * i, c_thr);
   endfunction

   function automatic rsp_type predict_duties(req_type r);
      rsp_type o;
      longint ia, ib, sn, cs, al, be, id, iq, vd, vq, vmax, vmin, dt;
      longint v[3];
      longint iref[3];
      ia = r.phase_a_current;
      ib = r.phase_b_current;
      sn = r.angle_sine;
      cs = r.angle_cosine;
      al = sat16(ia);
      be = sat16(round_shift((ia + 2 * ib) * INV_SQRT3_Q16, 16));
      id = sat16(round_shift(al * cs + be * sn, 14));
      iq = sat16(round_shift(-al * sn + be * cs, 14));
      vd = run_pi(d_integ, longint'(r.d_current_target) - id, d_kp, d_ki);
      vq = run_pi(q_integ, longint'(r.q_current_target) - iq, q_kp, q_ki);
      rotate_to_phases(vd, vq, sn, cs, v);
      rotate_to_phases(r.d_current_target, r.q_current_target, sn, cs, iref);
      for (int k = 0; k < 3; k++) v[k] = sat16(v[k] + deadtime_comp(iref[k]));
      vmax = v[0];
      vmin = v[0];
      for (int k = 1; k < 3; k++) begin
         if (v[k] > vmax) vmax = v[k];
         if (v[k] < vmin) vmin = v[k];
      end
      for (int k = 0; k < 3; k++) begin
         dt = DUTY_MID;
         if (bus_v != 0) dt = DUTY_MID + round_div(2048 * (2 * v[k] - vmax - vmin), bus_v);
         v[k] = clampv(dt, 0, DUTY_MAX);
      end
      o.duty_a = v[0][12:0];
      o.duty_b = v[1][12:0];
      o.duty_c = v[2][12:0];
      o.d_current = id[15:0];
      o.q_current = iq[15:0];
      return o;
   endfunction

   // Leaves the write enable high; write_all drops it after the last register.
   task automatic write_reg(csr_index_type idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      @(posedge clock);
      case (idx)
         CSR_D_PROP_GAIN:    d_kp = value & 16'hFFFF;
         CSR_D_INT_GAIN:     d_ki = value & 16'hFFFF;
         CSR_Q_PROP_GAIN:    q_kp = value & 16'hFFFF;
         CSR_Q_INT_GAIN:     q_ki = value & 16'hFFFF;
         CSR_VOLTAGE_LIMIT:  v_lim = value & 15'h7FFF;
         CSR_BUS_VOLTAGE:    bus_v = value & 15'h7FFF;
         CSR_COMP_AMPLITUDE: c_amp = value & 15'h7FFF;
         CSR_COMP_THRESHOLD: c_thr = value & 15'h7FFF;
         default: ;
      endcase
   endtask

   // Stops sending and waits out every pending result plus the block's worst-case latency.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(int dkp, int dki, int qkp, int qki, int lim, int bus,
                            int amp, int thr);
      wait_idle();
      write_reg(CSR_D_PROP_GAIN, dkp);
      write_reg(CSR_D_INT_GAIN, dki);
      write_reg(CSR_Q_PROP_GAIN, qkp);
      write_reg(CSR_Q_INT_GAIN, qki);
      write_reg(CSR_VOLTAGE_LIMIT, lim);
      write_reg(CSR_BUS_VOLTAGE, bus);
      write_reg(CSR_COMP_AMPLITUDE, amp);
      write_reg(CSR_COMP_THRESHOLD, thr);
      csr_write <= 1'b0;
   endtask

   // Leaves req_push high after the accepting edge; a wait drops it, the next send only while it idles.
   task automatic send_sample(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_duties.push_back(predict_duties(r));
   endtask

   function automatic req_type make_sample(int shape);
      req_type r;
      r.phase_a_current = 16'($urandom);
      r.phase_b_current = 16'($urandom);
      r.d_current_target = 16'($urandom);
      r.q_current_target = 16'($urandom);
      if (shape == 0) begin
         // Modest currents so the regulators work inside their limits.
         r.phase_a_current = 16'($signed($urandom_range(4096)) - 2048);
         r.phase_b_current = 16'($signed($urandom_range(4096)) - 2048);
         r.d_current_target = 16'($signed($urandom_range(2048)) - 1024);
         r.q_current_target = 16'($signed($urandom_range(4096)) - 2048);
      end
      if (shape == 2) begin
         r.angle_sine = 16'($urandom);
         r.angle_cosine = 16'($urandom);
      end else begin
         r.angle_sine = 16'($signed($urandom_range(32768)) - 16384);
         r.angle_cosine = 16'($signed($urandom_range(32768)) - 16384);
      end
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      int vals[5] = '{32767, -32768, 0, 1, -1};
      for (int k = 0; k < 5; k++) begin
         r.phase_a_current = 16'(vals[k]);
         r.phase_b_current = 16'(vals[(k + 1) % 5]);
         r.angle_sine = k[0] ? 16'(16384) : 16'(-16384);
         r.angle_cosine = k[1] ? 16'(-16384) : 16'(16384);
         r.d_current_target = 16'(vals[(k + 2) % 5]);
         r.q_current_target = 16'(vals[(k + 3) % 5]);
         send_sample(r);
      end
      // Out-of-range sine and cosine.
      r = '{16'(32767), 16'(32767), 16'(32767), 16'(-32768), 16'(-32768), 16'(32767)};
      send_sample(r);
      r = '{16'(0), 16'(0), 16'(16384), 16'(0), 16'(50), 16'(-50)};
      send_sample(r);
   endtask

   task automatic test_special_configs();
      req_type r;
      // Zero threshold with compensation active, then zero bus voltage.
      write_all(65535, 65535, 65535, 65535, 32767, 32767, 32767, 0);
      r = '{16'(0), 16'(0), 16'(0), 16'(16384), 16'(0), 16'(0)};
      send_sample(r);
      for (int k = 0; k < 4; k++) send_sample(make_sample(k % 3));
      write_all(0, 0, 0, 0, 0, 0, 0, 32767);
      for (int k = 0; k < 4; k++) send_sample(make_sample(k % 3));
      write_all(4096, 1024, 4096, 1024, 8192, 1, 500, 1);
      for (int k = 0; k < 4; k++) send_sample(make_sample(k % 3));
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
         send_sample(make_sample($urandom_range(9) < 7 ? 0 : $urandom_range(2)));
         // Hold off until everything is out, at least once per phase.
         if (k == count / 2) begin
            req_push <= 1'b0;
            while (expected_duties.size() != 0) @(posedge clock);
         end
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen <= results_seen + 1;
         if (expected_duties.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("Unexpected result %p", rsp_payload);
         end else begin
            exp_r = expected_duties.pop_front();
            if (rsp_payload !== exp_r) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("Result mismatch: expected %p, got %p",
                                              exp_r, rsp_payload);
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog on accepted traffic.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired");
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      d_kp = 6144; d_ki = 205; q_kp = 6144; q_ki = 205;
      v_lim = 2048; bus_v = 24576; c_amp = 0; c_thr = 102;
      d_integ = 0; q_integ = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_special_configs();
      write_all(6144, 205, 6144, 205, 2048, 24576, 300, 102);
      test_random_phase(0, 0, 75);
      write_all(20000, 2000, 3000, 50, 4000, 12288, 1000, 2000);
      test_random_phase(83, 0, 75);
      write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                $urandom_range(65535), $urandom_range(32767), $urandom_range(32767, 1),
                $urandom_range(32767), $urandom_range(32767, 1));
      test_random_phase(0, 83, 75);
      write_all(8192, 400, 8192, 400, 32767, 12000, 2000, 500);
      test_random_phase(22, 22, 75);
      req_push <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d current-loop results over eight register settings,", results_seen);
      $display("with free-running, sender-idle, receiver-stall and mixed flow control.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/focl_pkg.sv
design/focl_front.sv
design/focl_div.sv
design/focl_back.sv
design/foc_current_loop_unit.sv
tb/sv/tb_top.sv
